// ===== design/tga_rle_pkg.sv =====
`default_nettype none

package tga_rle_pkg;

    typedef logic [1:0] pixel_format_t;

    localparam pixel_format_t FMT_8BIT  = 2'd0;
    localparam pixel_format_t FMT_16BIT = 2'd1;
    localparam pixel_format_t FMT_24BIT = 2'd2;
    localparam pixel_format_t FMT_32BIT = 2'd3;

    localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;
    localparam logic [7:0] HDR_RUN_FLAG   = 8'h80;
    localparam logic [4:0] CHAN5_MASK     = 5'h1F;

    typedef struct packed {
        logic       packet_done;
        logic [7:0] repeat_count;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_result_t;

endpackage

`default_nettype wire

// ===== design/tga_rle_parser.sv =====
`default_nettype none

module tga_rle_parser
    import tga_rle_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    data_byte,
    input  wire pixel_format_t pixel_format,
    output logic               result_valid,
    output pixel_result_t      result
);

    logic        expect_header_reg, expect_header_next;
    logic        run_packet_reg, run_packet_next;
    logic [7:0]  pixels_left_reg, pixels_left_next;
    logic [1:0]  byte_position_reg, byte_position_next;
    logic [23:0] pixel_gather_reg, pixel_gather_next;

    logic [23:0] gather_merged;
    logic [7:0]  pixels_dec;
    logic        done;

    always_comb
    begin
        case (byte_position_reg)
            2'd0:    gather_merged = pixel_gather_reg | {16'd0, data_byte};
            2'd1:    gather_merged = pixel_gather_reg | {8'd0, data_byte, 8'd0};
            2'd2:    gather_merged = pixel_gather_reg | {data_byte, 16'd0};
            default: gather_merged = pixel_gather_reg;
        endcase
    end

    always_comb
    begin
        result.red          = 8'd0;
        result.green        = 8'd0;
        result.blue         = 8'd0;
        result.repeat_count = run_packet_reg ? pixels_left_reg : 8'd1;
        result.packet_done  = done;
        case (pixel_format)
            FMT_8BIT:
            begin
                result.red = gather_merged[7:0];
            end
            FMT_16BIT:
            begin
                result.red   = {gather_merged[14:10] & CHAN5_MASK, 3'd0};
                result.green = {gather_merged[9:5] & CHAN5_MASK, 3'd0};
                result.blue  = {gather_merged[4:0] & CHAN5_MASK, 3'd0};
            end
            default:
            begin
                result.blue  = gather_merged[7:0];
                result.green = gather_merged[15:8];
                result.red   = gather_merged[23:16];
            end
        endcase
    end

    assign pixels_dec = (pixels_left_reg != 8'd0) ? pixels_left_reg - 8'd1 : 8'd0;
    assign done       = run_packet_reg || (pixels_dec == 8'd0);

    always_comb
    begin
        expect_header_next = expect_header_reg;
        run_packet_next    = run_packet_reg;
        pixels_left_next   = pixels_left_reg;
        byte_position_next = byte_position_reg;
        pixel_gather_next  = pixel_gather_reg;
        result_valid       = 1'b0;
        if (accept)
        begin
            if (expect_header_reg)
            begin
                pixels_left_next   = (data_byte & HDR_COUNT_MASK) + 8'd1;
                run_packet_next    = (data_byte & HDR_RUN_FLAG) != 8'd0;
                expect_header_next = 1'b0;
                byte_position_next = 2'd0;
                pixel_gather_next  = 24'd0;
            end
            else if (byte_position_reg < pixel_format)
            begin
                byte_position_next = byte_position_reg + 2'd1;
                pixel_gather_next  = gather_merged;
            end
            else
            begin
                result_valid       = 1'b1;
                pixels_left_next   = run_packet_reg ? 8'd0 : pixels_dec;
                expect_header_next = done;
                byte_position_next = 2'd0;
                pixel_gather_next  = 24'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b1;
            run_packet_reg    <= 1'b0;
            pixels_left_reg   <= 8'd0;
            byte_position_reg <= 2'd0;
            pixel_gather_reg  <= 24'd0;
        end
        else
        begin
            expect_header_reg <= expect_header_next;
            run_packet_reg    <= run_packet_next;
            pixels_left_reg   <= pixels_left_next;
            byte_position_reg <= byte_position_next;
            pixel_gather_reg  <= pixel_gather_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/tga_rle_pixel_decoder_unit.sv =====
// TGA run-length pixel stream decoder.
// Slave channel (s_tvalid/s_tready/s_tdata) takes one compressed byte per
// transaction. Master channel (m_tvalid/m_tready/m_tdata/m_tlast) gives one
// pixel per transaction: red, green, blue and its repeat count; m_tlast
// marks the pixel that closes its packet. A run packet yields a single
// pixel with its count; literal pixels carry a count of one.
// The cfg channel (cfg_valid/cfg_ready/cfg_data) writes pixel_format; it is
// always ready and must be written only while the block is idle.
// Throughput: one byte per cycle while s_tready is high; the parser takes each accepted byte in one state update.
// A pixel is formed combinationally from the transaction carrying its last
// byte and registered into the main output register, or the skid stage if
// the receiver stalls. Header and partial-pixel bytes give no output.
// A main output register and a one-entry skid stage decouple the sides:
// input keeps flowing while a pixel waits, and s_tready drops only when
// both hold pixels under a stalled receiver.
// Reset clears the parser to await a packet header, empties the output
// stages and sets pixel_format to 24-bit.
`default_nettype none

module tga_rle_pixel_decoder_unit
    import tga_rle_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                        // [31:24] repeat_count
    output logic             m_tlast,   // packet_done
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data   // [1:0] pixel_format
);

    pixel_format_t pixel_format_reg;
    logic          accept;
    logic          res_valid;
    pixel_result_t res;

    logic          main_valid_reg, main_valid_next;
    pixel_result_t main_reg, main_next;
    logic          skid_valid_reg, skid_valid_next;
    pixel_result_t skid_reg, skid_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pixel_format_reg <= FMT_24BIT;
        else if (cfg_valid && cfg_ready)
            pixel_format_reg <= cfg_data;
    end

    tga_rle_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (s_tdata),
        .pixel_format (pixel_format_reg),
        .result_valid (res_valid),
        .result       (res)
    );

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = res_valid;
                main_next       = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {main_reg.repeat_count, main_reg.blue, main_reg.green, main_reg.red};
    assign m_tlast  = main_reg.packet_done;

endmodule

`default_nettype wire

// ===== design/tga_rle_checker.sv =====
`default_nettype none

module tga_rle_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast
);

    // hold a stalled pixel
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled pixel changed");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:24] != 8'd0)
        else $error("repeat count of zero");

    a_run_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[31:24] != 8'd1 |-> m_tlast)
        else $error("run pixel without packet end");

    a_backpressure_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && $past(m_tvalid))
        else $error("input stalled with empty output");

endmodule

bind tga_rle_pixel_decoder_unit tga_rle_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/tga_rle_stream_checker.sv =====
`timescale 1ns / 1ps

module tga_rle_stream_checker
    import tga_rle_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    input  wire logic          s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          m_tvalid,
    input  wire logic          m_tready,
    input  wire logic [31:0]   m_tdata,
    input  wire logic          m_tlast,
    input  wire logic          cfg_valid,
    input  wire logic          cfg_ready,
    input  wire pixel_format_t cfg_data,
    output int                 mismatch_count,
    output int                 pixels_owed,
    output logic               header_next
);

    pixel_format_t fmt;
    logic          want_header;
    logic          in_run;
    logic [7:0]    pixels_to_go;
    logic [1:0]    byte_idx;
    logic [23:0]   gathered;
    pixel_result_t pixel_q[$];

    function automatic pixel_result_t unpack_pixel(input logic [23:0] g, input pixel_format_t f);
        pixel_result_t p;
        p = '0;
        case (f)
            FMT_8BIT:
            begin
                p.red = g[7:0];
            end
            FMT_16BIT:
            begin
                p.red   = {g[14:10], 3'b000};
                p.green = {g[9:5], 3'b000};
                p.blue  = {g[4:0], 3'b000};
            end
            default:
            begin
                p.blue  = g[7:0];
                p.green = g[15:8];
                p.red   = g[23:16];
            end
        endcase
        return p;
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        pixel_result_t p;
        if (want_header)
        begin
            pixels_to_go = 8'((b & HDR_COUNT_MASK) + 8'd1);
            in_run       = |(b & HDR_RUN_FLAG);
            want_header  = 1'b0;
            byte_idx     = 2'd0;
            gathered     = 24'd0;
        end
        else
        begin
            if (byte_idx != 2'd3)
                gathered = gathered | (24'(b) << (8 * byte_idx));
            if (byte_idx < fmt)
            begin
                byte_idx = byte_idx + 2'd1;
            end
            else
            begin
                p = unpack_pixel(gathered, fmt);
                if (in_run)
                begin
                    p.repeat_count = pixels_to_go;
                    p.packet_done  = 1'b1;
                    pixels_to_go   = 8'd0;
                end
                else
                begin
                    p.repeat_count = 8'd1;
                    if (pixels_to_go != 8'd0)
                        pixels_to_go = pixels_to_go - 8'd1;
                    p.packet_done = (pixels_to_go == 8'd0);
                end
                if (p.packet_done)
                    want_header = 1'b1;
                byte_idx = 2'd0;
                gathered = 24'd0;
                pixel_q.push_back(p);
            end
        end
    endtask

    task automatic match_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_pixel(input pixel_result_t got);
        pixel_result_t want;
        if (pixel_q.size() == 0)
        begin
            $error("pixel with none pending: expected nothing, actual %h", got);
            mismatch_count++;
        end
        else
        begin
            want = pixel_q.pop_front();
            match_field("red", want.red, got.red);
            match_field("green", want.green, got.green);
            match_field("blue", want.blue, got.blue);
            match_field("repeat_count", want.repeat_count, got.repeat_count);
            match_field("packet_done", 8'(want.packet_done), 8'(got.packet_done));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt            = FMT_24BIT;
            want_header    = 1'b1;
            in_run         = 1'b0;
            pixels_to_go   = 8'd0;
            byte_idx       = 2'd0;
            gathered       = 24'd0;
            mismatch_count = 0;
            pixel_q.delete();
            pixels_owed <= 0;
            header_next <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                fmt = cfg_data;
            if (m_tvalid && m_tready)
                check_pixel({m_tlast, m_tdata});
            if (s_tvalid && s_tready)
                parse_byte(s_tdata);
            pixels_owed <= pixel_q.size();
            header_next <= want_header;
        end
    end

endmodule

// ===== tb/tb_tga_rle_pixel_decoder_unit.sv =====
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder_unit;
    import tga_rle_pkg::*;

    localparam int PHASES           = 12;
    localparam int PHASE_BYTES      = 64;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 4;
    localparam int WATCHDOG_LIMIT   = 2000;

    logic          clk           = 1'b0;
    logic          rst_n         = 1'b0;
    logic          s_tvalid      = 1'b0;
    logic          s_tready;
    logic [7:0]    s_tdata       = 8'h00;
    logic          m_tvalid;
    logic          m_tready      = 1'b0;
    logic [31:0]   m_tdata;
    logic          m_tlast;
    logic          cfg_valid     = 1'b0;
    logic          cfg_ready;
    pixel_format_t cfg_data      = FMT_24BIT;
    int            mismatch_count;
    int            pixels_owed;
    logic          header_next;
    logic          calm          = 1'b0;
    logic          src_gaps      = 1'b1;
    logic          sink_hold_req = 1'b0;
    pixel_format_t cur_fmt       = FMT_24BIT;
    int            idle_cycles   = 0;

    always #2 clk = ~clk;

    tga_rle_pixel_decoder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tga_rle_stream_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pixels_owed    (pixels_owed),
        .header_next    (header_next)
    );

    always
    begin
        @(posedge clk);
        if (sink_hold_req)
        begin
            sink_hold_req = 1'b0;
            m_tready <= 1'b0;
            repeat (SINK_HOLD_CYCLES) @(posedge clk);
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        m_tready <= 1'b1;
        if (!calm)
            repeat ($urandom_range(0, 30)) @(posedge clk);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb_tga_rle_pixel_decoder_unit: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        if (src_gaps && !calm && $urandom_range(0, 9) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic play(input logic [7:0] seq[$]);
        foreach (seq[i])
            push_byte(seq[i]);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pixels_owed != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_format(input pixel_format_t f);
        cfg_valid <= 1'b1;
        cfg_data  <= f;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_fmt = f;
    endtask

    // feed pixel bytes until the parser waits for a header
    task automatic realign();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (!header_next)
        begin
            push_byte(8'($urandom));
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic random_phase(input int budget);
        int   sent;
        int   npix;
        int   bpp;
        logic run;
        sent = 0;
        bpp  = int'(cur_fmt) + 1;
        while (sent < budget)
        begin
            run  = 1'($urandom_range(0, 1));
            npix = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 128))
                                               : int'($urandom_range(1, 6));
            push_byte({run, 7'(npix - 1)});
            sent++;
            if ($urandom_range(0, 24) == 0)
            begin
                repeat ($urandom_range(0, 3))
                begin
                    push_byte(8'($urandom));
                    sent++;
                end
                realign();
            end
            else
            begin
                repeat (run ? bpp : npix * bpp)
                begin
                    push_byte(8'($urandom));
                    sent++;
                end
            end
        end
        // sometimes leave a packet open across the format change
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
    endtask

    initial
    begin
        pixel_format_t order[4];
        int            ph;
        order = '{FMT_8BIT, FMT_32BIT, FMT_16BIT, FMT_24BIT};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        play({8'h80, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00,
              8'h00, 8'h12, 8'h34, 8'h56});
        settle();
        write_format(FMT_32BIT);
        play({8'h01, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'hEE, 8'h11});
        settle();
        write_format(FMT_16BIT);
        play({8'h5A});
        settle();
        write_format(FMT_8BIT);
        play({8'h81, 8'hFF, 8'h01, 8'h00, 8'h80});

        for (ph = 0; ph < PHASES; ph++)
        begin
            settle();
            write_format(ph < 4 ? order[ph] : pixel_format_t'($urandom_range(0, 3)));
            calm     = (ph >= PHASES - 2);
            src_gaps = !calm && ($urandom_range(0, 2) != 0);
            if (ph == 0)
                sink_hold_req = 1'b1;
            realign();
            random_phase(PHASE_BYTES);
        end
        settle();

        if (mismatch_count == 0 && pixels_owed == 0)
            $display("tb_tga_rle_pixel_decoder_unit: PASS");
        else
            $display("tb_tga_rle_pixel_decoder_unit: FAIL");
        $finish;
    end

endmodule
